>>> sv/mavg_pkg.sv
package mavg_pkg;

  localparam int DEPTH   = 16;
  localparam int SMP_W   = 24;
  localparam int USED_W  = 5;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int SUM_W   = SMP_W + $clog2(DEPTH);
  localparam int STEP_W  = $clog2(SUM_W);

  typedef logic signed [SMP_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [FILL_W-1:0]       fill_t;
  typedef logic [PTR_W-1:0]        ptr_t;
  typedef logic [USED_W-1:0]       used_t;
  typedef logic [STEP_W-1:0]       step_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  function automatic used_t to_used(fill_t fill);
    logic [31:0] wide;
    wide = 32'(fill);
    return wide[USED_W-1:0];
  endfunction

endpackage

>>> sv/mavg_ifs.sv
interface mavg_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [mavg_pkg::SMP_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mavg_out_if;
  logic                    valid;
  logic                    ready;
  logic signed [mavg_pkg::SMP_W-1:0] average;
  logic [mavg_pkg::USED_W-1:0]       samples_used;

  modport source (output valid, output average, output samples_used, input ready);
  modport sink   (input valid, input average, input samples_used, output ready);
endinterface

>>> sv/moving_average_with_warmup_unit.sv
// An accepted request passes the load, bit-serial sum update and bit-serial divide
// states; a new request is taken only after its result is loaded into the output
// register. The sum update and the divider each work one bit per cycle.
// Reset (synchronous, rst_n low): sum, fill count and write pointer cleared,
// output empty; ring contents are not cleared and are read only once written.
module moving_average_with_warmup_unit (
  input  logic        clk,
  input  logic        rst_n,
  mavg_in_if.sink     in_ch,
  mavg_out_if.source  out_ch
);
  import mavg_pkg::*;

  state_t  state_r, state_nxt;
  ptr_t    wp_r;
  fill_t   fill_r;
  logic    sub_r;
  sample_t sample_r;
  logic    out_valid_r;
  sample_t avg_r;
  used_t   used_r;

  logic    accept;
  logic    out_load;
  sample_t ring_rdata;
  sum_t    acc_sum;
  logic    acc_done;
  sample_t div_q;
  logic    div_done;
  logic    full;

  assign full     = (fill_r == fill_t'(DEPTH));
  assign accept   = in_ch.valid && (state_r == ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready = (state_r == ST_IDLE);

  mavg_ring u_ring (
    .clk   (clk),
    .we    (accept),
    .addr  (wp_r),
    .wdata (in_ch.sample),
    .rdata (ring_rdata)
  );

  mavg_acc u_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == ST_LOAD),
    .sub    (sub_r),
    .sample (sample_r),
    .old    (ring_rdata),
    .sum    (acc_sum),
    .done   (acc_done)
  );

  mavg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_ACC && acc_done),
    .dividend (acc_sum),
    .divisor  (fill_r),
    .quotient (div_q),
    .done     (div_done)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_ACC;
      ST_ACC:  if (acc_done) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        wp_r <= (wp_r == ptr_t'(DEPTH - 1)) ? '0 : wp_r + ptr_t'(1);
        if (!full) begin
          fill_r <= fill_r + fill_t'(1);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_ch.sample;
      sub_r    <= full;
    end
    if (out_load) begin
      avg_r  <= div_q;
      used_r <= to_used(fill_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.average      = avg_r;
  assign out_ch.samples_used = used_r;

endmodule

>>> sv/mavg_ring.sv
module mavg_ring (
  input  logic                clk,
  input  logic                we,
  input  mavg_pkg::ptr_t      addr,
  input  mavg_pkg::sample_t   wdata,
  output mavg_pkg::sample_t   rdata
);
  import mavg_pkg::*;

  sample_t mem [DEPTH];
  sample_t rdata_r;

  // read-before-write: rdata_r gets the sample being replaced
  always_ff @(posedge clk) begin
    rdata_r <= mem[addr];
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/mavg_acc.sv
module mavg_acc (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                sub,
  input  mavg_pkg::sample_t   sample,
  input  mavg_pkg::sample_t   old,
  output mavg_pkg::sum_t      sum,
  output logic                done
);
  import mavg_pkg::*;

  sum_t       sum_r;
  sample_t    smp_sh_r;
  sample_t    old_sh_r;
  logic [1:0] carry_r;
  step_t      cnt_r;
  logic       busy_r;
  logic       done_r;
  logic [2:0] bit_sum;

  // sum + sample + ~old + 1, one bit per cycle, LSB first
  assign bit_sum = {2'b00, sum_r[0]} + {2'b00, smp_sh_r[0]} + {2'b00, ~old_sh_r[0]}
                 + {1'b0, carry_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        sum_r <= {bit_sum[0], sum_r[SUM_W-1:1]};
        cnt_r <= cnt_r + step_t'(1);
        if (cnt_r == step_t'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      smp_sh_r <= sample;
      old_sh_r <= sub ? old : '0;
      carry_r  <= 2'd1;
    end else if (busy_r) begin
      smp_sh_r <= smp_sh_r >>> 1;
      old_sh_r <= old_sh_r >>> 1;
      carry_r  <= bit_sum[2:1];
    end
  end

  assign sum  = sum_r;
  assign done = done_r;

endmodule

>>> sv/mavg_div.sv
module mavg_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  mavg_pkg::sum_t      dividend,
  input  mavg_pkg::fill_t     divisor,
  output mavg_pkg::sample_t   quotient,
  output logic                done
);
  import mavg_pkg::*;

  logic [SUM_W-1:0]  dq_r;
  fill_t             rem_r;
  logic              neg_r;
  step_t             cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [FILL_W+1:0] diff;
  logic              qbit;
  sample_t           q_mag;

  assign diff  = {1'b0, rem_r, dq_r[SUM_W-1]} - {2'b00, divisor};
  assign qbit  = ~diff[FILL_W+1];
  assign q_mag = dq_r[SMP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + step_t'(1);
        if (cnt_r == step_t'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division of |dividend|, quotient shifts in at the LSB
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      dq_r  <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem_r <= '0;
    end else if (busy_r) begin
      dq_r  <= {dq_r[SUM_W-2:0], qbit};
      rem_r <= qbit ? diff[FILL_W-1:0] : {rem_r[FILL_W-2:0], dq_r[SUM_W-1]};
    end
  end

  assign quotient = neg_r ? -q_mag : q_mag;
  assign done     = done_r;

endmodule
